// File: rtl/tds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the task dependency scoreboard.
// No dependencies; used by tds_ctrl, tds_datapath, task_dependency_scoreboard and the test files.
package tds_pkg;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;
  localparam int CODE_W   = 2;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 8;

  localparam logic [CNT_W-1:0] TASK_COUNT_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_DEP = 2'd0,
    OP_SCAN    = 2'd1,
    OP_DONE    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [CODE_W-1:0] {
    RES_NONE         = 2'd0,
    RES_START        = 2'd1,
    RES_BAD_INDEX    = 2'd2,
    RES_DONE_BLOCKED = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    ST_BLOCKED   = 2'd0,
    ST_RUNNABLE  = 2'd1,
    ST_COMPLETED = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

endpackage

// File: rtl/tds_ctrl.sv
`timescale 1ns / 1ps
// Controller of the scoreboard: request handshake, execute sequencing, output valid.
// Depends on tds_pkg.
module tds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output tds_pkg::ctrl_cmd_t cmd
);
  import tds_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid && !m_tready;
    unique case (state)
      S_IDLE: begin
        s_tready   = !rst;
        cmd.accept = s_tvalid && !rst;
      end
      S_EXEC: begin
        cmd.commit = out_free;
        if (out_free) out_valid_next = 1'b1;
      end
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == S_EXEC))
    else $error("request accepted but no execute cycle followed");
  a_commit_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("commit without a result");
  a_stall_holds_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && m_tvalid && !m_tready) |=> (state == S_EXEC) && !s_tready)
    else $error("execute left while output stalled");
`endif

endmodule

// File: rtl/tds_datapath.sv
`timescale 1ns / 1ps
// Scoreboard datapath: parent matrix memory, task status, scan pointer, result register.
// Depends on tds_pkg; sequenced by tds_ctrl.
module tds_datapath #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tds_pkg::ctrl_cmd_t           cmd,
  input  logic [tds_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         cfg_wr_en,
  input  logic [tds_pkg::CNT_W-1:0]    cfg_wr_data,
  output logic [tds_pkg::M_DATA_W-1:0] m_tdata
);
  import tds_pkg::*;

  localparam int TW   = $clog2(MAX_TASKS);
  localparam int CW   = $clog2(MAX_TASKS + 1);
  localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

  logic [CNT_W-1:0]     task_count;
  logic [CMPW-1:0]      tc_ext;
  logic [CMPW-1:0]      n;

  op_t                  in_op;
  logic [IDX_W-1:0]     in_task;
  logic [IDX_W-1:0]     in_parent;
  logic [CMPW-1:0]      in_task_ext;
  logic [TW-1:0]        vis;
  logic [TW-1:0]        rd_addr;

  op_t                  op_q;
  logic [IDX_W-1:0]     task_q;
  logic [IDX_W-1:0]     parent_q;
  logic [TW-1:0]        vis_q;
  logic [TW-1:0]        scan_ptr;
  logic [TW-1:0]        ptr_next;

  logic [MAX_TASKS-1:0] dep_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] row_valid;
  logic [MAX_TASKS-1:0] row_q;
  logic                 row_valid_q;
  logic [MAX_TASKS-1:0] row_eff;
  logic [MAX_TASKS-1:0] wr_row;
  logic                 mem_we;

  status_t              status [MAX_TASKS];
  logic                 st_we;
  status_t              st_val;
  logic [TW-1:0]        st_idx;

  logic [MAX_TASKS-1:0] act_mask;
  logic [MAX_TASKS-1:0] comp_mask;
  logic                 need_open;
  logic [CMPW-1:0]      task_ext_q;
  logic [CMPW-1:0]      parent_ext_q;
  logic [TW-1:0]        task_idx;
  logic [TW-1:0]        parent_idx;
  logic [CMPW-1:0]      vis_inc;
  res_t                 code;
  logic [IDX_W-1:0]     rtask;

  // task count, clamped to 1..MAX_TASKS
  always_comb begin
    tc_ext = CMPW'(task_count);
    if (tc_ext == '0) begin
      n = CMPW'(1);
    end else if (tc_ext > CMPW'(MAX_TASKS)) begin
      n = CMPW'(MAX_TASKS);
    end else begin
      n = tc_ext;
    end
  end

  assign in_op       = op_t'(s_tdata[1:0]);
  assign in_task     = s_tdata[5:2];
  assign in_parent   = s_tdata[9:6];
  assign in_task_ext = CMPW'(in_task);
  assign vis         = (CMPW'(scan_ptr) >= n) ? '0 : scan_ptr;
  assign rd_addr     = (in_op == OP_ADD_DEP) ? in_task_ext[TW-1:0] : vis;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= TASK_COUNT_RESET;
    end else if (cfg_wr_en) begin
      task_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= in_op;
      task_q   <= in_task;
      parent_q <= in_parent;
      vis_q    <= vis;
    end
  end

  // parent rows; a row never written reads as zero through row_valid
  always_ff @(posedge clk) begin
    if (cmd.accept) row_q <= dep_mem[rd_addr];
    if (mem_we) dep_mem[task_idx] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid   <= '0;
      row_valid_q <= 1'b0;
    end else begin
      if (cmd.accept) row_valid_q <= row_valid[rd_addr];
      if (mem_we) row_valid[task_idx] <= 1'b1;
    end
  end

  assign task_ext_q   = CMPW'(task_q);
  assign parent_ext_q = CMPW'(parent_q);
  assign task_idx     = task_ext_q[TW-1:0];
  assign parent_idx   = parent_ext_q[TW-1:0];
  assign row_eff      = row_valid_q ? row_q : '0;
  assign wr_row       = row_eff | ({{(MAX_TASKS-1){1'b0}}, 1'b1} << parent_idx);
  assign vis_inc      = CMPW'(vis_q) + CMPW'(1);

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      act_mask[i]  = (CMPW'(i) < n);
      comp_mask[i] = (status[i] == ST_COMPLETED);
    end
  end

  assign need_open = |(row_eff & act_mask & ~comp_mask);

  always_comb begin
    code     = RES_NONE;
    rtask    = '0;
    mem_we   = 1'b0;
    st_we    = 1'b0;
    st_val   = ST_BLOCKED;
    st_idx   = task_idx;
    ptr_next = scan_ptr;
    unique case (op_q)
      OP_ADD_DEP: begin
        if (task_ext_q >= n) begin
          code  = RES_BAD_INDEX;
          rtask = task_q;
        end else if (parent_ext_q >= n) begin
          code  = RES_BAD_INDEX;
          rtask = parent_q;
        end else begin
          mem_we = cmd.commit;
        end
      end
      OP_SCAN: begin
        ptr_next = (vis_inc >= n) ? '0 : vis_inc[TW-1:0];
        st_idx   = vis_q;
        if (status[vis_q] == ST_BLOCKED && !need_open) begin
          st_we  = cmd.commit;
          st_val = ST_RUNNABLE;
          code   = RES_START;
          rtask  = IDX_W'(vis_q);
        end else if (status[vis_q] == ST_RUNNABLE) begin
          code  = RES_START;
          rtask = IDX_W'(vis_q);
        end
      end
      OP_DONE: begin
        if (task_ext_q >= n) begin
          code  = RES_BAD_INDEX;
          rtask = task_q;
        end else if (status[task_idx] == ST_BLOCKED) begin
          code  = RES_DONE_BLOCKED;
          rtask = task_q;
        end else if (status[task_idx] == ST_RUNNABLE) begin
          st_we  = cmd.commit;
          st_val = ST_COMPLETED;
        end
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        status[i] <= ST_BLOCKED;
      end
    end else if (cmd.commit) begin
      scan_ptr <= ptr_next;
      if (st_we) status[st_idx] <= st_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {{(M_DATA_W - IDX_W - CODE_W){1'b0}}, rtask, code};
    end
  end

`ifndef SYNTHESIS
  a_start_is_runnable: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && op_q == OP_SCAN && code == RES_START) |=> (status[vis_q] == ST_RUNNABLE))
    else $error("start announced for a task that is not runnable");
  a_done_sticks: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && op_q == OP_DONE && code == RES_NONE)
      |=> (status[task_idx] == ST_COMPLETED))
    else $error("completion did not leave the task completed");
  a_add_marks_row: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && op_q == OP_ADD_DEP && code == RES_NONE) |=> row_valid[task_idx])
    else $error("dependency row not marked written");
`endif

endmodule

// File: rtl/task_dependency_scoreboard.sv
`timescale 1ns / 1ps
// Top level of the task dependency scoreboard.
// Depends on tds_pkg, tds_ctrl and tds_datapath.
//
// Requests arrive on s_tvalid/s_tready/s_tdata: add a parent dependency, scan tick
// (visit the next task round robin), task completed or no operation. Every request
// produces exactly one result on m_tvalid/m_tready/m_tdata: nothing, task can start,
// unknown task index or completion of a blocked task, plus the task the code refers to.
// cfg_wr_en/cfg_wr_data set the number of tasks in use; write only while idle.
// A request is accepted in the idle state; its result is registered when execute
// commits. The parent row is read from a memory with a registered read port at
// acceptance and evaluated in the execute state; no new request is taken in execute.
// s_tready is high in the idle state, so a new request is taken while the previous
// result waits in the output register. If the receiver stalls, the next request stays
// in execute until the output register frees.
// Reset (rst, synchronous) clears all dependencies, marks every task blocked, sets the
// scan pointer to 0 and the task count to 16; s_tready stays low while rst is high.
// No clearing pass is needed.
module task_dependency_scoreboard #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [1:0] operation, [5:2] task_index, [9:6] parent_index, [15:10] zero
  input  logic [tds_pkg::S_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [1:0] result_code, [5:2] result_task, [7:6] zero
  output logic [tds_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                         cfg_wr_en,
  input  logic [tds_pkg::CNT_W-1:0]    cfg_wr_data
);
  import tds_pkg::*;

  ctrl_cmd_t cmd;

  tds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tds_datapath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .s_tdata     (s_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tdata     (m_tdata)
  );

endmodule

// File: test/tds_outcome_checker.sv
`timescale 1ns / 1ps
// Result checker for the task dependency scoreboard: tracks requests, count writes and results,
// keeps its own copy of dependency rows, task status and scan pointer, and compares in order.
// Depends on tds_pkg.
module tds_outcome_checker #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [tds_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [tds_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                         cfg_wr_en,
  input  logic [tds_pkg::CNT_W-1:0]    cfg_wr_data,
  output int                           errors,
  output int                           pending,
  output int                           checked
);
  import tds_pkg::*;

  typedef struct packed {
    res_t             code;
    logic [IDX_W-1:0] tid;
  } outcome_t;

  logic [MAX_TASKS-1:0] parents [MAX_TASKS];
  status_t              status  [MAX_TASKS];
  logic [IDX_W-1:0]     scan_ptr;
  logic [CNT_W-1:0]     task_count;
  outcome_t             outcome_q [$];

  function automatic outcome_t resolve_request(op_t op, logic [IDX_W-1:0] t,
                                               logic [IDX_W-1:0] p);
    outcome_t             r;
    int                   n;
    int                   v;
    int                   i;
    logic [MAX_TASKS-1:0] live;
    logic [MAX_TASKS-1:0] done_set;
    r.code = RES_NONE;
    r.tid  = '0;
    n = (task_count == 0) ? 1 : ((task_count > MAX_TASKS) ? MAX_TASKS : int'(task_count));
    live = (n >= MAX_TASKS) ? '1 : ((MAX_TASKS'(1) << n) - MAX_TASKS'(1));
    done_set = '0;
    for (i = 0; i < MAX_TASKS; i++) begin
      done_set[i] = (status[i] == ST_COMPLETED);
    end
    case (op)
      OP_ADD_DEP: begin
        if (t >= n) begin
          r.code = RES_BAD_INDEX;
          r.tid  = t;
        end else if (p >= n) begin
          r.code = RES_BAD_INDEX;
          r.tid  = p;
        end else begin
          parents[t][p] = 1'b1;
        end
      end
      OP_SCAN: begin
        v = scan_ptr;
        if (v >= n) v = 0;
        // stale parents above the count are masked off
        if (status[v] == ST_BLOCKED && (parents[v] & live & ~done_set) == '0)
          status[v] = ST_RUNNABLE;
        if (status[v] == ST_RUNNABLE) begin
          r.code = RES_START;
          r.tid  = IDX_W'(v);
        end
        v++;
        if (v >= n) v = 0;
        scan_ptr = IDX_W'(v);
      end
      OP_DONE: begin
        if (t >= n) begin
          r.code = RES_BAD_INDEX;
          r.tid  = t;
        end else if (status[t] == ST_BLOCKED) begin
          r.code = RES_DONE_BLOCKED;
          r.tid  = t;
        end else if (status[t] == ST_RUNNABLE) begin
          status[t] = ST_COMPLETED;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    int       i;
    if (rst) begin
      for (i = 0; i < MAX_TASKS; i++) begin
        parents[i] = '0;
        status[i]  = ST_BLOCKED;
      end
      scan_ptr   = '0;
      task_count = TASK_COUNT_RESET;
      errors     = 0;
      checked    = 0;
      outcome_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.code = res_t'(m_tdata[1:0]);
        got.tid  = m_tdata[5:2];
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: expected no result, got code %s task %0d",
                   $time, got.code.name(), got.tid);
        end else begin
          want = outcome_q.pop_front();
          checked++;
          if (got.code !== want.code || got.tid !== want.tid) begin
            errors++;
            $display("%0t: expected code %s task %0d, got code %s (%0d) task %0d",
                     $time, want.code.name(), want.tid, got.code.name(),
                     m_tdata[1:0], got.tid);
          end
        end
      end
      if (cfg_wr_en) task_count = cfg_wr_data;
      if (s_tvalid && s_tready)
        outcome_q = {outcome_q,
                     resolve_request(op_t'(s_tdata[1:0]), s_tdata[5:2], s_tdata[9:6])};
    end
    pending <= outcome_q.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the task dependency scoreboard: reset, count writes, directed and
// random request streams with random stalls on both sides. Depends on tds_pkg, the
// task_dependency_scoreboard RTL and tds_outcome_checker.
module testbench;
  import tds_pkg::*;

  localparam int MAX_TASKS = 16;

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                s_tvalid    = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata     = '0;
  logic                m_tvalid;
  logic                m_tready    = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]    cfg_wr_data = '0;
  logic                calm        = 1'b0;
  int                  errors;
  int                  pending;
  int                  checked;
  int                  sent        = 0;
  int                  settings    = 0;

  always #5 clk = ~clk;

  task_dependency_scoreboard #(.MAX_TASKS(MAX_TASKS)) uut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  tds_outcome_checker #(.MAX_TASKS(MAX_TASKS)) outcome_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) m_tready <= !rst && (calm || $urandom_range(99) >= 18);

  task automatic send(input op_t op, input logic [IDX_W-1:0] t, input logic [IDX_W-1:0] p);
    while (!calm && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - OP_W - 2 * IDX_W){1'b0}}, p, t, op};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_task_count(input logic [CNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings++;
  endtask

  // mostly in-range requests; adds lean toward lower parents so chains can resolve
  task automatic random_burst(input logic [CNT_W-1:0] count_val, input int items,
                              input logic steady);
    int               n;
    int               k;
    int               roll;
    op_t              op;
    logic [IDX_W-1:0] t;
    logic [IDX_W-1:0] p;
    drain();
    set_task_count(count_val);
    n = (count_val == 0) ? 1 : ((count_val > MAX_TASKS) ? MAX_TASKS : int'(count_val));
    calm <= steady;
    for (k = 0; k < items; k++) begin
      roll = $urandom_range(99);
      t = IDX_W'($urandom_range(n - 1));
      p = IDX_W'($urandom_range(n - 1));
      if (roll < 6) begin
        op = op_t'($urandom_range(3));
        t  = IDX_W'($urandom);
        p  = IDX_W'($urandom);
      end else if (roll < 36) begin
        op = OP_ADD_DEP;
        if (t != 0 && roll < 33) p = IDX_W'($urandom_range(int'(t) - 1));
      end else if (roll < 76) begin
        op = OP_SCAN;
      end else begin
        op = OP_DONE;
      end
      send(op, t, p);
    end
    calm <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset count of 16
    send(OP_ADD_DEP, 4'd1, 4'd0);
    send(OP_ADD_DEP, 4'd1, 4'd14);
    send(OP_ADD_DEP, 4'd1, 4'd0);
    send(OP_ADD_DEP, 4'd15, 4'd15);
    send(OP_DONE, 4'd1, 4'd0);
    send(OP_SCAN, 4'd0, 4'd0);
    send(OP_SCAN, 4'd15, 4'd15);
    send(OP_DONE, 4'd0, 4'd0);
    send(OP_DONE, 4'd0, 4'd15);
    send(OP_NOP, 4'd15, 4'd15);

    // shrink below the scan pointer; parent 14 of task 1 goes stale
    drain();
    set_task_count(5'd2);
    send(OP_SCAN, 4'd0, 4'd0);
    send(OP_SCAN, 4'd0, 4'd0);
    send(OP_ADD_DEP, 4'd2, 4'd0);
    send(OP_ADD_DEP, 4'd0, 4'd3);
    send(OP_DONE, 4'd15, 4'd0);
    send(OP_DONE, 4'd1, 4'd0);

    drain();
    set_task_count(5'd0);
    send(OP_SCAN, 4'd0, 4'd0);
    send(OP_ADD_DEP, 4'd1, 4'd0);

    drain();
    set_task_count(5'd31);
    send(OP_ADD_DEP, 4'd14, 4'd13);
    send(OP_SCAN, 4'd0, 4'd0);
    send(OP_DONE, 4'd15, 4'd0);
    send(OP_SCAN, 4'd0, 4'd0);

    random_burst(5'd0, 60, 1'b0);
    random_burst(5'd1, 60, 1'b0);
    random_burst(5'd2, 80, 1'b0);
    random_burst(5'd4, 100, 1'b0);
    random_burst(5'd7, 100, 1'b0);
    random_burst(5'd10, 120, 1'b0);
    random_burst(5'd16, 150, 1'b1);
    random_burst(5'd31, 110, 1'b0);
    random_burst(5'd17, 100, 1'b0);
    random_burst(CNT_W'($urandom_range(1, MAX_TASKS)), 100, 1'b0);
    drain();

    $display("Sent %0d requests over %0d task-count settings, %0d results compared.",
             sent, settings, checked);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: task_dependency_scoreboard.f
rtl/tds_pkg.sv
rtl/tds_ctrl.sv
rtl/tds_datapath.sv
rtl/task_dependency_scoreboard.sv
test/tds_outcome_checker.sv
test/testbench.sv
